>>> rtl/core/rv32ie_pkg.sv
// Shared types, opcode and field codes, and helpers for the RV32I executor.
// No dependencies; every other file in rtl/core refers to this package.
package rv32ie_pkg;

    // Architectural defaults
    localparam int unsigned NUM_REGS_DEFAULT     = 32;
    localparam logic [31:0] START_ADDRESS_RESET  = 32'h0000_0000;
    localparam logic [31:0] U_IMM_MASK           = 32'hFFFF_F000;
    localparam logic [31:0] PC_STEP              = 32'd4;

    // Major opcodes
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_FENCE  = 7'h0F;
    localparam logic [6:0] OP_SYSTEM = 7'h73;

    // Branch funct3
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    // Load / store funct3 (also the pending load kind)
    localparam logic [2:0] F3_LB  = 3'd0;
    localparam logic [2:0] F3_LH  = 3'd1;
    localparam logic [2:0] F3_LW  = 3'd2;
    localparam logic [2:0] F3_LBU = 3'd4;
    localparam logic [2:0] F3_LHU = 3'd5;
    localparam logic [2:0] F3_SB  = 3'd0;
    localparam logic [2:0] F3_SH  = 3'd1;
    localparam logic [2:0] F3_SW  = 3'd2;

    // ALU funct3
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // Input command codes
    localparam logic CMD_EXEC     = 1'b0;
    localparam logic CMD_LOAD_RET = 1'b1;

    // Memory request codes
    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_LOAD  = 2'd1;
    localparam logic [1:0] MEM_STORE = 2'd2;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    // Input transaction
    typedef struct packed {
        logic        cmd;
        logic [31:0] instruction;
        logic [31:0] load_data;
    } in_item_t;

    // Result transaction
    typedef struct packed {
        logic [31:0] next_pc;
        logic [1:0]  mem_op;
        logic [31:0] mem_address;
        logic [1:0]  mem_size;
        logic [31:0] store_data;
        logic        write_valid;
        logic [4:0]  write_index;
        logic [31:0] write_value;
        logic        unknown_opcode;
    } out_item_t;

    // Register file write port
    typedef struct packed {
        logic        en;
        logic [4:0]  idx;
        logic [31:0] data;
    } rf_wr_t;

    // Outstanding load bookkeeping
    typedef struct packed {
        logic       pending;
        logic [4:0] dest;
        logic [2:0] kind;
    } ld_state_t;

    // True for a register that exists and is not x0
    function automatic logic reg_in_range(input logic [4:0] idx, input int unsigned num_regs);
        reg_in_range = (idx != 5'd0) && (32'(idx) < num_regs);
    endfunction

endpackage

>>> rtl/core/rv32i_instruction_executor_top.sv
// Top level of the RV32I executor: input register, architectural state, result register.
// Depends on rv32ie_pkg, rv32ie_regfile and rv32ie_exec.
//
//   channel   ports                      payload        direction
//   input     s_valid / s_ready / s_data in_item_t      in
//   result    m_valid / m_ready / m_data out_item_t     out
//   config    cfg_wr_en / cfg_wr_data    start_address  in
//
// One transaction per cycle in steady state while results are taken; each sits in the
// input register (register file read) and then executes into the result register.
// Result valid rises as the transaction moves from the input register into
// the result register.
// A full result register that is not taken holds the executing transaction in place.
// Synchronous active-low reset clears control state, the register file valid bits,
// any pending load, and loads the PC with the start address reset value.
module rv32i_instruction_executor_top #(
    parameter int unsigned NUM_REGS = rv32ie_pkg::NUM_REGS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [31:0]           cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  rv32ie_pkg::in_item_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rv32ie_pkg::out_item_t m_data
);

    logic                  in_vld_reg;
    rv32ie_pkg::in_item_t  in_item_reg;
    logic                  out_vld_reg;
    rv32ie_pkg::out_item_t out_item_reg;
    logic [31:0]           pc_reg;
    rv32ie_pkg::ld_state_t ld_reg;
    logic [31:0]           start_address_reg;
    logic [31:0]           start_address_next;

    logic                  s_fire;
    logic                  exec_go;
    logic [31:0]           rs1_val, rs2_val;
    rv32ie_pkg::out_item_t exec_res;
    logic [31:0]           exec_pc_next;
    rv32ie_pkg::rf_wr_t    exec_wr;
    rv32ie_pkg::rf_wr_t    rf_wr;
    rv32ie_pkg::ld_state_t exec_ld_next;

    // Advance when the result register is free or being drained
    assign exec_go = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || exec_go;
    assign s_fire  = s_valid && s_ready;

    // Commit register writes only when the transaction executes
    always_comb begin
        rf_wr    = exec_wr;
        rf_wr.en = exec_wr.en && exec_go;
    end

    // Start address register; reset restores its reset value
    always_comb begin
        if (!aresetn) begin
            start_address_next = rv32ie_pkg::START_ADDRESS_RESET;
        end else if (cfg_wr_en) begin
            start_address_next = cfg_wr_data;
        end else begin
            start_address_next = start_address_reg;
        end
    end

    always_ff @(posedge aclk) begin
        start_address_reg <= start_address_next;
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_fire) begin
            in_vld_reg <= 1'b1;
        end else if (exec_go) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg <= s_data;
        end
    end

    // Architectural state: PC and pending load
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= start_address_next;
            ld_reg <= '0;
        end else if (exec_go) begin
            pc_reg <= exec_pc_next;
            ld_reg <= exec_ld_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (exec_go) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_go) begin
            out_item_reg <= exec_res;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_item_reg;

    rv32ie_regfile #(
        .NUM_REGS (NUM_REGS)
    ) u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (s_fire),
        .rd_addr_a (s_data.instruction[19:15]),
        .rd_addr_b (s_data.instruction[24:20]),
        .rd_data_a (rs1_val),
        .rd_data_b (rs2_val),
        .wr        (rf_wr)
    );

    rv32ie_exec #(
        .NUM_REGS (NUM_REGS)
    ) u_exec (
        .item    (in_item_reg),
        .rs1_val (rs1_val),
        .rs2_val (rs2_val),
        .pc      (pc_reg),
        .ld      (ld_reg),
        .res     (exec_res),
        .pc_next (exec_pc_next),
        .rf_wr   (exec_wr),
        .ld_next (exec_ld_next)
    );

endmodule

>>> rtl/core/rv32ie_regfile.sv
// Integer register file: two synchronous read ports, one write port, reset valid bits.
// Depends on rv32ie_pkg for the write port struct and the range helper.
module rv32ie_regfile #(
    parameter int unsigned NUM_REGS = rv32ie_pkg::NUM_REGS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rd_en,
    input  logic [4:0]           rd_addr_a,
    input  logic [4:0]           rd_addr_b,
    output logic [31:0]          rd_data_a,
    output logic [31:0]          rd_data_b,
    input  rv32ie_pkg::rf_wr_t   wr
);

    localparam int unsigned IDX_W = $clog2(NUM_REGS);

    logic [31:0]         mem [NUM_REGS];
    logic [NUM_REGS-1:0] valid_reg;

    logic [31:0] mem_a_reg,  mem_b_reg;
    logic [31:0] byp_a_reg,  byp_b_reg;
    logic        hit_a_reg,  hit_b_reg;
    logic        vld_a_reg,  vld_b_reg;
    logic        live_a_reg, live_b_reg;

    // Write the array; writes to x0 and absent registers are already dropped upstream
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.idx[IDX_W-1:0]] <= wr.data;
        end
    end

    // Mark written entries; reset makes every entry read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.en) begin
            valid_reg[wr.idx[IDX_W-1:0]] <= 1'b1;
        end
    end

    // Read both ports; capture a same-edge write for bypass
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            mem_a_reg  <= mem[rd_addr_a[IDX_W-1:0]];
            mem_b_reg  <= mem[rd_addr_b[IDX_W-1:0]];
            vld_a_reg  <= valid_reg[rd_addr_a[IDX_W-1:0]];
            vld_b_reg  <= valid_reg[rd_addr_b[IDX_W-1:0]];
            live_a_reg <= rv32ie_pkg::reg_in_range(rd_addr_a, NUM_REGS);
            live_b_reg <= rv32ie_pkg::reg_in_range(rd_addr_b, NUM_REGS);
            hit_a_reg  <= wr.en && (wr.idx == rd_addr_a);
            hit_b_reg  <= wr.en && (wr.idx == rd_addr_b);
            byp_a_reg  <= wr.data;
            byp_b_reg  <= wr.data;
        end
    end

    // Select bypass, stored value or zero
    always_comb begin
        rd_data_a = '0;
        rd_data_b = '0;
        if (live_a_reg) begin
            if (hit_a_reg) begin
                rd_data_a = byp_a_reg;
            end else if (vld_a_reg) begin
                rd_data_a = mem_a_reg;
            end
        end
        if (live_b_reg) begin
            if (hit_b_reg) begin
                rd_data_b = byp_b_reg;
            end else if (vld_b_reg) begin
                rd_data_b = mem_b_reg;
            end
        end
    end

endmodule

>>> rtl/core/rv32ie_exec.sv
// Decode and execute one transaction: ALU, branch, address generation, load return.
// Depends on rv32ie_pkg for the transaction structs, codes and range helper.
module rv32ie_exec #(
    parameter int unsigned NUM_REGS = rv32ie_pkg::NUM_REGS_DEFAULT
) (
    input  rv32ie_pkg::in_item_t  item,
    input  logic [31:0]           rs1_val,
    input  logic [31:0]           rs2_val,
    input  logic [31:0]           pc,
    input  rv32ie_pkg::ld_state_t ld,
    output rv32ie_pkg::out_item_t res,
    output logic [31:0]           pc_next,
    output rv32ie_pkg::rf_wr_t    rf_wr,
    output rv32ie_pkg::ld_state_t ld_next
);

    logic [31:0] ins;
    logic [6:0]  opcode;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic        alt;
    logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;
    logic [31:0] opnd_b;
    logic [4:0]  shamt;
    logic [31:0] alu_res;
    logic        taken;
    logic        dowr;
    logic [31:0] wr_val;
    logic [31:0] ld_val;
    logic        is_reg;

    // Split the word and form the immediates
    always_comb begin
        ins    = item.instruction;
        opcode = ins[6:0];
        f3     = ins[14:12];
        rd     = ins[11:7];
        alt    = ins[30];
        imm_i  = {{20{ins[31]}}, ins[31:20]};
        imm_s  = {{20{ins[31]}}, ins[31:25], ins[11:7]};
        imm_b  = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
        imm_u  = ins & rv32ie_pkg::U_IMM_MASK;
        imm_j  = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
        is_reg = (opcode == rv32ie_pkg::OP_REG);
        opnd_b = is_reg ? rs2_val : imm_i;
        shamt  = opnd_b[4:0];
    end

    // ALU for register and immediate forms
    always_comb begin
        case (f3)
            rv32ie_pkg::F3_ADD:  alu_res = (is_reg && alt) ? rs1_val - opnd_b : rs1_val + opnd_b;
            rv32ie_pkg::F3_SLL:  alu_res = rs1_val << shamt;
            rv32ie_pkg::F3_SLT:  alu_res = {31'd0, $signed(rs1_val) < $signed(opnd_b)};
            rv32ie_pkg::F3_SLTU: alu_res = {31'd0, rs1_val < opnd_b};
            rv32ie_pkg::F3_XOR:  alu_res = rs1_val ^ opnd_b;
            rv32ie_pkg::F3_SR:   alu_res = alt ? 32'($signed(rs1_val) >>> shamt)
                                               : rs1_val >> shamt;
            rv32ie_pkg::F3_OR:   alu_res = rs1_val | opnd_b;
            default:             alu_res = rs1_val & opnd_b;
        endcase
    end

    // Branch condition; undefined encodings never branch
    always_comb begin
        case (f3)
            rv32ie_pkg::F3_BEQ:  taken = rs1_val == rs2_val;
            rv32ie_pkg::F3_BNE:  taken = rs1_val != rs2_val;
            rv32ie_pkg::F3_BLT:  taken = $signed(rs1_val) < $signed(rs2_val);
            rv32ie_pkg::F3_BGE:  taken = !($signed(rs1_val) < $signed(rs2_val));
            rv32ie_pkg::F3_BLTU: taken = rs1_val < rs2_val;
            rv32ie_pkg::F3_BGEU: taken = rs1_val >= rs2_val;
            default:             taken = 1'b0;
        endcase
    end

    // Extend returned load data by the recorded kind
    always_comb begin
        case (ld.kind)
            rv32ie_pkg::F3_LB:  ld_val = {{24{item.load_data[7]}}, item.load_data[7:0]};
            rv32ie_pkg::F3_LH:  ld_val = {{16{item.load_data[15]}}, item.load_data[15:0]};
            rv32ie_pkg::F3_LBU: ld_val = {24'd0, item.load_data[7:0]};
            rv32ie_pkg::F3_LHU: ld_val = {16'd0, item.load_data[15:0]};
            default:            ld_val = item.load_data;
        endcase
    end

    // Main decode: next PC, memory request, write-back and load bookkeeping
    always_comb begin
        res      = '0;
        dowr     = 1'b0;
        wr_val   = '0;
        ld_next  = ld;
        pc_next  = pc;
        rf_wr    = '0;

        if (item.cmd == rv32ie_pkg::CMD_LOAD_RET) begin
            // Retire the outstanding load, if any; PC holds
            if (ld.pending) begin
                dowr            = 1'b1;
                wr_val          = ld_val;
                ld_next.pending = 1'b0;
            end
            rf_wr.idx = ld.dest;
        end else begin
            pc_next   = pc + rv32ie_pkg::PC_STEP;
            rf_wr.idx = rd;
            case (opcode)
                rv32ie_pkg::OP_LUI: begin
                    dowr   = 1'b1;
                    wr_val = imm_u;
                end
                rv32ie_pkg::OP_AUIPC: begin
                    dowr   = 1'b1;
                    wr_val = pc + imm_u;
                end
                rv32ie_pkg::OP_JAL: begin
                    dowr    = 1'b1;
                    wr_val  = pc + rv32ie_pkg::PC_STEP;
                    pc_next = pc + imm_j;
                end
                rv32ie_pkg::OP_JALR: begin
                    dowr    = 1'b1;
                    wr_val  = pc + rv32ie_pkg::PC_STEP;
                    pc_next = (rs1_val + imm_i) & ~32'd1;
                end
                rv32ie_pkg::OP_BRANCH: begin
                    if (taken) begin
                        pc_next = pc + imm_b;
                    end
                end
                rv32ie_pkg::OP_LOAD: begin
                    if (f3 inside {rv32ie_pkg::F3_LB, rv32ie_pkg::F3_LH, rv32ie_pkg::F3_LW,
                                   rv32ie_pkg::F3_LBU, rv32ie_pkg::F3_LHU}) begin
                        res.mem_op      = rv32ie_pkg::MEM_LOAD;
                        res.mem_address = rs1_val + imm_i;
                        res.mem_size    = f3[1:0];
                        ld_next.pending = 1'b1;
                        ld_next.dest    = rd;
                        ld_next.kind    = f3;
                    end
                end
                rv32ie_pkg::OP_STORE: begin
                    if (f3 inside {rv32ie_pkg::F3_SB, rv32ie_pkg::F3_SH,
                                   rv32ie_pkg::F3_SW}) begin
                        res.mem_op      = rv32ie_pkg::MEM_STORE;
                        res.mem_address = rs1_val + imm_s;
                        res.mem_size    = f3[1:0];
                        case (f3)
                            rv32ie_pkg::F3_SB: res.store_data = {24'd0, rs2_val[7:0]};
                            rv32ie_pkg::F3_SH: res.store_data = {16'd0, rs2_val[15:0]};
                            default:           res.store_data = rs2_val;
                        endcase
                    end
                end
                rv32ie_pkg::OP_IMM, rv32ie_pkg::OP_REG: begin
                    dowr   = 1'b1;
                    wr_val = alu_res;
                end
                rv32ie_pkg::OP_FENCE, rv32ie_pkg::OP_SYSTEM: begin
                end
                default: begin
                    // Unrecognised opcode: hold the PC and flag it
                    pc_next            = pc;
                    res.unknown_opcode = 1'b1;
                end
            endcase
        end

        // Drop writes to x0 and absent registers
        rf_wr.en   = dowr && rv32ie_pkg::reg_in_range(rf_wr.idx, NUM_REGS);
        rf_wr.data = wr_val;

        res.next_pc     = pc_next;
        res.write_valid = rf_wr.en;
        res.write_index = rf_wr.en ? rf_wr.idx : 5'd0;
        res.write_value = rf_wr.en ? wr_val : 32'd0;
    end

endmodule

>>> rtl/core/rv32ie_checker.sv
// Port-level checks on the RV32I executor result channel, bound to the top level.
// Depends on rv32ie_pkg for the memory request codes.
module rv32ie_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input rv32ie_pkg::out_item_t m_data
);

    // Hold a stalled result transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Nothing leaves the block straight after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A write-back never targets x0, and an absent write carries zeros
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.write_valid && m_data.write_index != 5'd0) ||
                    (!m_data.write_valid && m_data.write_index == 5'd0 &&
                     m_data.write_value == 32'd0))
        else $error("inconsistent write-back fields");

    // No memory request: address, size and store data are zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.mem_op == rv32ie_pkg::MEM_NONE |->
            m_data.mem_address == 32'd0 && m_data.mem_size == rv32ie_pkg::SIZE_BYTE &&
            m_data.store_data == 32'd0)
        else $error("stray memory request fields");

    // An unknown opcode makes no request and no write
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.unknown_opcode |->
            m_data.mem_op == rv32ie_pkg::MEM_NONE && !m_data.write_valid)
        else $error("unknown opcode with side effects");

endmodule

bind rv32i_instruction_executor_top rv32ie_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

>>> test/rv32i_instruction_executor_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for rv32i_instruction_executor_top: directed and random
// instruction streams against an in-bench model of the executor. Needs rv32ie_pkg.
module rv32i_instruction_executor_top_test;

    localparam int unsigned REG_COUNT   = rv32ie_pkg::NUM_REGS_DEFAULT;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          SETTLE      = 6;
    localparam int          IDLE_PCT    = 8;

    // Field values that have no package name
    localparam logic [2:0] F3_BR_UNDEF = 3'd2;
    localparam logic [2:0] F3_LD_UNDEF = 3'd3;
    localparam logic [2:0] F3_ST_UNDEF = 3'd7;
    localparam logic [2:0] F3_NONE     = 3'd0;
    localparam logic [6:0] F7_ALT      = 7'b0100000;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [31:0]           cfg_wr_data = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    rv32ie_pkg::in_item_t  s_data      = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    rv32ie_pkg::out_item_t m_data;

    // Architectural state mirrored by the bench
    logic [31:0] arch_regs [32];
    logic [31:0] arch_pc;
    logic        ld_pending;
    logic [4:0]  ld_dest;
    logic [2:0]  ld_kind;

    rv32ie_pkg::in_item_t  pending_items[$];
    rv32ie_pkg::out_item_t expected_results[$];
    rv32ie_pkg::out_item_t oldest_result;
    int                    mismatches  = 0;
    int                    cycle_count = 0;
    logic                  steady_run  = 1'b0;

    rv32i_instruction_executor_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always #5 aclk = ~aclk;

    // Register read: x0 and absent registers read as zero
    function automatic logic [31:0] read_reg(logic [4:0] idx);
        if (idx == 5'd0 || 32'(idx) >= REG_COUNT)
            return 32'd0;
        return arch_regs[idx];
    endfunction

    // Advance the mirrored state by one transaction and return its result
    function automatic rv32ie_pkg::out_item_t execute_item(rv32ie_pkg::in_item_t it);
        rv32ie_pkg::out_item_t r;
        logic [31:0] ins, a, b, c, res;
        logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;
        logic [6:0]  op;
        logic [2:0]  f3;
        logic [4:0]  rd;
        logic        do_wr, taken;
        r = '0;
        r.next_pc = arch_pc;
        do_wr = 1'b0;
        res = '0;
        rd = '0;
        if (it.cmd == rv32ie_pkg::CMD_LOAD_RET) begin
            if (ld_pending) begin
                case (ld_kind)
                    rv32ie_pkg::F3_LB:  res = {{24{it.load_data[7]}}, it.load_data[7:0]};
                    rv32ie_pkg::F3_LH:  res = {{16{it.load_data[15]}}, it.load_data[15:0]};
                    rv32ie_pkg::F3_LBU: res = {24'd0, it.load_data[7:0]};
                    rv32ie_pkg::F3_LHU: res = {16'd0, it.load_data[15:0]};
                    default:            res = it.load_data;
                endcase
                do_wr = 1'b1;
                rd = ld_dest;
                ld_pending = 1'b0;
            end
        end else begin
            ins   = it.instruction;
            op    = ins[6:0];
            f3    = ins[14:12];
            rd    = ins[11:7];
            a     = read_reg(ins[19:15]);
            b     = read_reg(ins[24:20]);
            imm_i = {{20{ins[31]}}, ins[31:20]};
            imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
            imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
            imm_u = ins & rv32ie_pkg::U_IMM_MASK;
            imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
            r.next_pc = arch_pc + rv32ie_pkg::PC_STEP;
            case (op)
                rv32ie_pkg::OP_LUI: begin
                    do_wr = 1'b1;
                    res = imm_u;
                end
                rv32ie_pkg::OP_AUIPC: begin
                    do_wr = 1'b1;
                    res = arch_pc + imm_u;
                end
                rv32ie_pkg::OP_JAL: begin
                    do_wr = 1'b1;
                    res = arch_pc + rv32ie_pkg::PC_STEP;
                    r.next_pc = arch_pc + imm_j;
                end
                rv32ie_pkg::OP_JALR: begin
                    do_wr = 1'b1;
                    res = arch_pc + rv32ie_pkg::PC_STEP;
                    r.next_pc = (a + imm_i) & ~32'd1;
                end
                rv32ie_pkg::OP_BRANCH: begin
                    case (f3)
                        rv32ie_pkg::F3_BEQ:  taken = (a == b);
                        rv32ie_pkg::F3_BNE:  taken = (a != b);
                        rv32ie_pkg::F3_BLT:  taken = ($signed(a) < $signed(b));
                        rv32ie_pkg::F3_BGE:  taken = !($signed(a) < $signed(b));
                        rv32ie_pkg::F3_BLTU: taken = (a < b);
                        rv32ie_pkg::F3_BGEU: taken = (a >= b);
                        default:             taken = 1'b0;
                    endcase
                    if (taken)
                        r.next_pc = arch_pc + imm_b;
                end
                rv32ie_pkg::OP_LOAD: begin
                    case (f3)
                        rv32ie_pkg::F3_LB, rv32ie_pkg::F3_LH, rv32ie_pkg::F3_LW,
                        rv32ie_pkg::F3_LBU, rv32ie_pkg::F3_LHU: begin
                            r.mem_op = rv32ie_pkg::MEM_LOAD;
                            r.mem_address = a + imm_i;
                            r.mem_size = f3[1:0];
                            ld_pending = 1'b1;
                            ld_dest = rd;
                            ld_kind = f3;
                        end
                        default: ;
                    endcase
                end
                rv32ie_pkg::OP_STORE: begin
                    if (f3 <= rv32ie_pkg::F3_SW) begin
                        r.mem_op = rv32ie_pkg::MEM_STORE;
                        r.mem_address = a + imm_s;
                        r.mem_size = f3[1:0];
                        case (f3)
                            rv32ie_pkg::F3_SB: r.store_data = {24'd0, b[7:0]};
                            rv32ie_pkg::F3_SH: r.store_data = {16'd0, b[15:0]};
                            default:           r.store_data = b;
                        endcase
                    end
                end
                rv32ie_pkg::OP_IMM, rv32ie_pkg::OP_REG: begin
                    c = (op == rv32ie_pkg::OP_REG) ? b : imm_i;
                    do_wr = 1'b1;
                    case (f3)
                        rv32ie_pkg::F3_ADD:
                            res = (op == rv32ie_pkg::OP_REG && ins[30]) ? a - c : a + c;
                        rv32ie_pkg::F3_SLL:  res = a << c[4:0];
                        rv32ie_pkg::F3_SLT:  res = {31'd0, $signed(a) < $signed(c)};
                        rv32ie_pkg::F3_SLTU: res = {31'd0, a < c};
                        rv32ie_pkg::F3_XOR:  res = a ^ c;
                        rv32ie_pkg::F3_SR:   res = ins[30] ? $unsigned($signed(a) >>> c[4:0])
                                                           : a >> c[4:0];
                        rv32ie_pkg::F3_OR:   res = a | c;
                        default:             res = a & c;
                    endcase
                end
                rv32ie_pkg::OP_FENCE, rv32ie_pkg::OP_SYSTEM: ;
                default: begin
                    r.next_pc = arch_pc;
                    r.unknown_opcode = 1'b1;
                end
            endcase
            arch_pc = r.next_pc;
        end
        // Drop writes to x0 and to absent registers
        if (do_wr && rd != 5'd0 && 32'(rd) < REG_COUNT) begin
            arch_regs[rd] = res;
            r.write_valid = 1'b1;
            r.write_index = rd;
            r.write_value = res;
        end
        return r;
    endfunction

    function automatic int field_diff(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Instruction encoders
    function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
        return {f7, rs2, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                          logic [4:0] rd, logic [6:0] op);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], rv32ie_pkg::OP_STORE};
    endfunction

    function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], rv32ie_pkg::OP_BRANCH};
    endfunction

    function automatic logic [31:0] enc_u(logic [19:0] imm, logic [4:0] rd, logic [6:0] op);
        return {imm, rd, op};
    endfunction

    function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, rv32ie_pkg::OP_JAL};
    endfunction

    // Favour the low registers so that operands collide often
    function automatic logic [4:0] pick_reg();
        if ($urandom_range(0, 1) == 0)
            return 5'($urandom_range(0, 7));
        return 5'($urandom_range(0, 31));
    endfunction

    task automatic queue_exec(logic [31:0] ins);
        rv32ie_pkg::in_item_t it;
        it.cmd = rv32ie_pkg::CMD_EXEC;
        it.instruction = ins;
        it.load_data = $urandom();
        pending_items.push_back(it);
    endtask

    task automatic queue_load_return(logic [31:0] data);
        rv32ie_pkg::in_item_t it;
        it.cmd = rv32ie_pkg::CMD_LOAD_RET;
        it.instruction = $urandom();
        it.load_data = data;
        pending_items.push_back(it);
    endtask

    // Mostly well-formed instructions with random fields; some noise and stray returns
    task automatic queue_random_items(int count);
        int          kind;
        logic [4:0]  rd, rs1, rs2;
        logic [2:0]  f3;
        logic [31:0] word;
        for (int n = 0; n < count; n++) begin
            rd   = pick_reg();
            rs1  = pick_reg();
            rs2  = pick_reg();
            f3   = 3'($urandom_range(0, 7));
            word = $urandom();
            kind = $urandom_range(0, 99);
            if (kind < 10) begin
                queue_exec(enc_u(word[31:12], rd, rv32ie_pkg::OP_LUI));
            end else if (kind < 14) begin
                queue_exec(enc_u(word[31:12], rd, rv32ie_pkg::OP_AUIPC));
            end else if (kind < 18) begin
                queue_exec(enc_j(word[20:0], rd));
            end else if (kind < 22) begin
                queue_exec(enc_i(word[11:0], rs1, f3, rd, rv32ie_pkg::OP_JALR));
            end else if (kind < 34) begin
                queue_exec(enc_b(word[12:0], rs2, rs1, f3));
            end else if (kind < 46) begin
                queue_exec(enc_i(word[11:0], rs1, f3, rd, rv32ie_pkg::OP_LOAD));
                if ($urandom_range(0, 9) < 8)
                    queue_load_return($urandom());
            end else if (kind < 56) begin
                if ($urandom_range(0, 4) != 0)
                    f3 = 3'($urandom_range(0, 2));
                queue_exec(enc_s(word[11:0], rs2, rs1, f3));
            end else if (kind < 74) begin
                queue_exec(enc_i(word[11:0], rs1, f3, rd, rv32ie_pkg::OP_IMM));
            end else if (kind < 90) begin
                queue_exec(enc_r(word[31:25], rs2, rs1, f3, rd, rv32ie_pkg::OP_REG));
            end else if (kind < 93) begin
                queue_exec({word[31:7], ($urandom_range(0, 1) != 0) ? rv32ie_pkg::OP_FENCE
                                                                     : rv32ie_pkg::OP_SYSTEM});
            end else if (kind < 97) begin
                queue_exec(word);
            end else begin
                queue_load_return(word);
            end
        end
    endtask

    // Hold until every transaction is through, then let the pipeline settle
    task automatic drain();
        @(negedge aclk);
        while (pending_items.size() != 0 || s_valid || expected_results.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic set_start_address(logic [31:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(negedge aclk);
    endtask

    // Driver: offer the next queued transaction, predict on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_results.push_back(execute_item(s_data));
            if (!s_valid || s_ready) begin
                if (pending_items.size() != 0 &&
                    (steady_run || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_items.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result with the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %p", $time, m_data);
                    mismatches++;
                end else begin
                    oldest_result = expected_results.pop_front();
                    mismatches += field_diff("next_pc", oldest_result.next_pc, m_data.next_pc);
                    mismatches += field_diff("mem_op", 32'(oldest_result.mem_op),
                                             32'(m_data.mem_op));
                    mismatches += field_diff("mem_address", oldest_result.mem_address,
                                             m_data.mem_address);
                    mismatches += field_diff("mem_size", 32'(oldest_result.mem_size),
                                             32'(m_data.mem_size));
                    mismatches += field_diff("store_data", oldest_result.store_data,
                                             m_data.store_data);
                    mismatches += field_diff("write_valid", 32'(oldest_result.write_valid),
                                             32'(m_data.write_valid));
                    mismatches += field_diff("write_index", 32'(oldest_result.write_index),
                                             32'(m_data.write_index));
                    mismatches += field_diff("write_value", oldest_result.write_value,
                                             m_data.write_value);
                    mismatches += field_diff("unknown_opcode", 32'(oldest_result.unknown_opcode),
                                             32'(m_data.unknown_opcode));
                end
            end
            m_ready <= steady_run || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < 32; i++)
            arch_regs[i] = '0;
        arch_pc    = rv32ie_pkg::START_ADDRESS_RESET;
        ld_pending = 1'b0;
        ld_dest    = '0;
        ld_kind    = '0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes, each format and the corner cases
        set_start_address(32'hFFFF_FFFF);
        queue_exec(enc_u(20'hFFFFF, 5'd1, rv32ie_pkg::OP_LUI));
        queue_exec(enc_i(12'hFFF, 5'd0, rv32ie_pkg::F3_ADD, 5'd2, rv32ie_pkg::OP_IMM));
        queue_exec(enc_i(12'h7FF, 5'd0, rv32ie_pkg::F3_ADD, 5'd3, rv32ie_pkg::OP_IMM));
        queue_exec(enc_u(20'h80000, 5'd4, rv32ie_pkg::OP_AUIPC));
        queue_exec(enc_r(F7_ALT, 5'd2, 5'd3, rv32ie_pkg::F3_ADD, 5'd5, rv32ie_pkg::OP_REG));
        // Stray funct7 bits beside the alternate bit must be ignored
        queue_exec(enc_r(7'h7F, 5'd2, 5'd1, rv32ie_pkg::F3_SR, 5'd6, rv32ie_pkg::OP_REG));
        queue_exec(enc_r(7'h5F, 5'd3, 5'd2, rv32ie_pkg::F3_SLL, 5'd7, rv32ie_pkg::OP_REG));
        queue_exec(enc_i(12'h41F, 5'd1, rv32ie_pkg::F3_SR, 5'd8, rv32ie_pkg::OP_IMM));
        queue_exec(enc_i(12'hFFF, 5'd1, rv32ie_pkg::F3_SLTU, 5'd9, rv32ie_pkg::OP_IMM));
        queue_exec(enc_r(7'h00, 5'd3, 5'd1, rv32ie_pkg::F3_XOR, 5'd10, rv32ie_pkg::OP_REG));
        queue_exec(enc_i(12'h005, 5'd2, rv32ie_pkg::F3_ADD, 5'd0, rv32ie_pkg::OP_IMM));
        queue_exec(enc_b(13'h1000, 5'd2, 5'd2, rv32ie_pkg::F3_BEQ));
        queue_exec(enc_b(13'h0FFE, 5'd1, 5'd3, rv32ie_pkg::F3_BLTU));
        queue_exec(enc_b(13'h0010, 5'd0, 5'd0, F3_BR_UNDEF));
        queue_exec(enc_j(21'h0FFFFE, 5'd11));
        queue_exec(enc_i(12'hFFF, 5'd2, rv32ie_pkg::F3_ADD, 5'd12, rv32ie_pkg::OP_JALR));
        queue_exec(enc_i(12'h800, 5'd3, rv32ie_pkg::F3_LB, 5'd13, rv32ie_pkg::OP_LOAD));
        queue_load_return(32'h0000_0080);
        queue_exec(enc_i(12'h7FF, 5'd2, rv32ie_pkg::F3_LHU, 5'd14, rv32ie_pkg::OP_LOAD));
        queue_load_return(32'hFFFF_8000);
        queue_exec(enc_i(12'h000, 5'd1, F3_LD_UNDEF, 5'd15, rv32ie_pkg::OP_LOAD));
        queue_load_return(32'hFFFF_FFFF);
        queue_exec(enc_s(12'hFFF, 5'd2, 5'd1, rv32ie_pkg::F3_SB));
        queue_exec(enc_s(12'h7FF, 5'd1, 5'd2, rv32ie_pkg::F3_SW));
        queue_exec(enc_s(12'h000, 5'd2, 5'd1, F3_ST_UNDEF));
        queue_exec(enc_i(12'h0FF, 5'd0, F3_NONE, 5'd0, rv32ie_pkg::OP_FENCE));
        queue_exec(enc_i(12'h000, 5'd0, F3_NONE, 5'd0, rv32ie_pkg::OP_SYSTEM));
        queue_exec(32'hFFFF_FFFF);
        drain();

        // Random phases; the first runs with no idling on either side
        set_start_address(32'h0000_0000);
        steady_run = 1'b1;
        queue_random_items(350);
        drain();
        steady_run = 1'b0;

        set_start_address($urandom());
        queue_random_items(350);
        drain();

        set_start_address(32'h8000_0000);
        queue_random_items(300);
        drain();

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
